@@ design/bps_pkg.sv @@
`timescale 1ns / 1ps

package bps_pkg;

  localparam int TICK_W     = 15;
  localparam int STEP_W     = 3;
  localparam int STATE_W    = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int NUM_PATTERNS = 9;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_BEEP  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_BEEP   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_REST   = 4'd3;

  localparam logic [TICK_W-1:0] RST_SHORT_BEEP  = 15'd100;
  localparam logic [TICK_W-1:0] RST_LONG_BEEP   = 15'd500;
  localparam logic [TICK_W-1:0] RST_SPACING     = 15'd100;
  localparam logic [TICK_W-1:0] RST_TAIL_REST   = 15'd1000;

  typedef enum logic [2:0] {
    DUR_SHORT,
    DUR_LONG,
    DUR_GAP,
    DUR_PGAP,
    DUR_AGAP
  } dur_sel_t;

  typedef struct packed {
    logic [TICK_W-1:0] short_beep;
    logic [TICK_W-1:0] long_beep;
    logic [TICK_W-1:0] spacing;
    logic [TICK_W-1:0] tail_rest;
  } cfg_t;

  // pattern length, 1..8
  function automatic logic [3:0] pattern_len(input logic [STATE_W-1:0] fs);
    logic [3:0] len;
    case (fs)
      4'd0: len = 4'd2;
      4'd1: len = 4'd4;
      4'd2: len = 4'd6;
      4'd3: len = 4'd1;
      4'd4: len = 4'd2;
      4'd5: len = 4'd8;
      4'd6: len = 4'd2;
      4'd7: len = 4'd6;
      4'd8: len = 4'd2;
      default: len = 4'd1;
    endcase
    return len;
  endfunction

  // v in 0..8, len one of 1, 2, 4, 6, 8
  function automatic logic [STEP_W-1:0] mod_len(input logic [3:0] v, input logic [3:0] len);
    logic [STEP_W-1:0] r;
    case (len)
      4'd1: r = '0;
      4'd2: r = {2'b00, v[0]};
      4'd4: r = {1'b0, v[1:0]};
      4'd6: r = (v >= 4'd6) ? 3'(v - 4'd6) : v[2:0];
      default: r = v[2:0];
    endcase
    return r;
  endfunction

  function automatic dur_sel_t step_dur(input logic [STATE_W-1:0] fs,
                                        input logic [STEP_W-1:0] idx);
    dur_sel_t d;
    logic [3:0] len;
    len = pattern_len(fs);
    if (fs == 4'd3) begin
      d = DUR_PGAP;
    end else if ({1'b0, idx} == len - 4'd1) begin
      case (fs)
        4'd6: d = DUR_GAP;
        4'd8: d = DUR_AGAP;
        default: d = DUR_PGAP;
      endcase
    end else if (idx[0]) begin
      d = DUR_GAP;
    end else if (fs == 4'd4 || fs == 4'd7) begin
      d = DUR_LONG;
    end else begin
      d = DUR_SHORT;
    end
    return d;
  endfunction

  // every pattern sounds on its even steps, except coast which is silent
  function automatic logic step_on(input logic [STATE_W-1:0] fs,
                                   input logic [STEP_W-1:0] idx);
    return (fs != 4'd3) && !idx[0];
  endfunction

endpackage

@@ design/buzzer_pattern_sequencer_top.sv @@
`timescale 1ns / 1ps

// Buzzer pattern sequencer.
// Each transaction on the s_axis channel is one millisecond tick carrying the
// flight state (0..8 picks one of nine on/off patterns, 9..15 hold the step
// index and buzzer level). Every tick yields exactly one transaction on
// m_axis with the buzzer level and the step index after that tick.
// Step times come from four registers written through the cfg channel
// (index 0 short beep, 1 long beep, 2 beep gap, 3 pattern gap; others are
// dropped). cfg_ready is always high; write only while no tick is in flight.
// A tick is taken into the input register and, once m_axis can advance,
// moves into the sequencer state register that drives m_axis.
// Throughput: one tick per cycle while m_axis does not stall; the tick update is a
// single saturating add, a compare and a table lookup between those two registers.
// When m_axis stalls, the input register still takes one more tick, then
// s_axis_tready drops until the result is taken.
// Reset clears both stages, the elapsed count, step index and buzzer level,
// and restores the register defaults 100, 500, 100 and 1000.
module buzzer_pattern_sequencer_top
  import bps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [3:0] flight_state
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // [0] buzzer_level, [3:1] step_position
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  cfg_t               cfg;
  logic               in_valid;
  logic [STATE_W-1:0] in_state;
  logic               advance;
  logic               buzzer_level;
  logic [STEP_W-1:0]  step_position;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        m_axis_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_state <= s_axis_tdata[STATE_W-1:0];
    end
  end

  bps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bps_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .tick          (advance && in_valid),
    .flight_state  (in_state),
    .buzzer_level  (buzzer_level),
    .step_position (step_position)
  );

  assign m_axis_tdata = {4'b0000, step_position, buzzer_level};

endmodule

@@ design/bps_cfg.sv @@
`timescale 1ns / 1ps

module bps_cfg
  import bps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_beep <= RST_SHORT_BEEP;
      cfg.long_beep  <= RST_LONG_BEEP;
      cfg.spacing    <= RST_SPACING;
      cfg.tail_rest  <= RST_TAIL_REST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SHORT_BEEP: cfg.short_beep <= cfg_data;
        REG_LONG_BEEP:  cfg.long_beep  <= cfg_data;
        REG_SPACING:    cfg.spacing    <= cfg_data;
        REG_TAIL_REST:  cfg.tail_rest  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ design/bps_seq.sv @@
`timescale 1ns / 1ps

module bps_seq
  import bps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               tick,
  input  logic [STATE_W-1:0] flight_state,
  output logic               buzzer_level,
  output logic [STEP_W-1:0]  step_position
);

  logic [TICK_W-1:0] elapsed;
  logic [TICK_W-1:0] elapsed_inc;
  logic [TICK_W-1:0] dur;
  logic [3:0]        len;
  logic [STEP_W-1:0] cur;
  logic [STEP_W-1:0] step_next;
  dur_sel_t          sel;
  logic              known;
  logic              hit;

  always_comb begin
    known       = flight_state < 4'(NUM_PATTERNS);
    len         = pattern_len(flight_state);
    cur         = mod_len({1'b0, step_position}, len);
    step_next   = mod_len({1'b0, step_position} + 4'd1, len);
    sel         = step_dur(flight_state, cur);
    elapsed_inc = (elapsed == TICK_MAX) ? elapsed : elapsed + 1'b1;
    case (sel)
      DUR_SHORT: dur = cfg.short_beep;
      DUR_LONG:  dur = cfg.long_beep;
      DUR_GAP:   dur = cfg.spacing;
      DUR_PGAP:  dur = cfg.tail_rest;
      default:   dur = cfg.spacing >> 1;
    endcase
    hit = known && (elapsed_inc >= dur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed       <= '0;
      step_position <= '0;
      buzzer_level  <= 1'b0;
    end else if (tick) begin
      if (hit) begin
        elapsed       <= '0;
        step_position <= step_next;
        buzzer_level  <= step_on(flight_state, step_next);
      end else begin
        elapsed <= elapsed_inc;
      end
    end
  end

endmodule

@@ design/bps_checker.sv @@
`timescale 1ns / 1ps

module bps_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("m_axis_tvalid dropped during stall");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("m_axis_tdata changed during stall");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_on_even_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1])
    else $error("buzzer on at an odd step");

endmodule

bind buzzer_pattern_sequencer_top bps_checker u_bps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
